FILE: src/soil_moisture_irrigation_control_assert.svh
// assertion macros for the irrigation controller
// expects clk and rst_n in the scope of every use; no other dependencies
`ifndef SOIL_MOISTURE_IRRIGATION_CONTROL_ASSERT_SVH
`define SOIL_MOISTURE_IRRIGATION_CONTROL_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SMIC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in a cycle implies outcome in the next
`define SMIC_ASSERT_NEXT(lbl, trig, outcome, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
    else $error(msg);

`endif

FILE: src/smic_pkg.sv
// shared types, codes and arithmetic helpers of the irrigation controller
// no dependencies; used by smic_debounce and soil_moisture_irrigation_control
package smic_pkg;

  // request codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUMP  = 2'd1;
  localparam logic [1:0] OP_SETPT = 2'd2;

  // message kinds
  localparam logic [2:0] KIND_STATUS    = 3'd0;
  localparam logic [2:0] KIND_TANK_LOW  = 3'd1;
  localparam logic [2:0] KIND_TANK_HIGH = 3'd2;
  localparam logic [2:0] KIND_MOISTURE  = 3'd3;
  localparam logic [2:0] KIND_SETPOINT  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_DOSE     = 3'd0;
  localparam logic [2:0] CFG_SAMPLE   = 3'd1;
  localparam logic [2:0] CFG_REPORT   = 3'd2;
  localparam logic [2:0] CFG_SP_MIN   = 3'd3;
  localparam logic [2:0] CFG_SP_MAX   = 3'd4;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam int          NSLOT = 6;

  // one outgoing message
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] value;
    logic       pump_on;
  } msg_t;

  // debounced pin status toward the top level
  typedef struct packed {
    logic flag;
    logic flag_nxt;
    logic chg;
  } dbn_t;

  function automatic msg_t mk_msg(logic [2:0] kind, logic [6:0] value, logic pump_on);
    msg_t m;
    m.kind    = kind;
    m.value   = value;
    m.pump_on = pump_on;
    return m;
  endfunction

  // (670-adc)*100/393 truncated, clamped to 0..100
  // quotient via reciprocal 66704/2^18, exact for d up to 396
  function automatic logic [6:0] percent_of(logic [9:0] adc);
    logic [9:0]  d;
    logic [26:0] prod;
    logic [6:0]  p;
    d    = 10'(11'd670 - {1'b0, adc});
    prod = 27'(d) * 27'd66704;
    if (adc >= 10'd670) begin
      p = 7'd0;
    end else if (d >= 10'd397) begin
      p = 7'd100;
    end else begin
      p = prod[24:18];
    end
    return p;
  endfunction

  // y/11 for y up to 1100, reciprocal 1490/2^14
  function automatic logic [6:0] div11(logic [10:0] y);
    logic [21:0] prod;
    prod = 22'(y) * 22'd1490;
    return prod[20:14];
  endfunction

  // start condition of a watering attempt
  function automatic logic start_ok(logic tank_low, logic [6:0] avg,
                                    logic [6:0] sp_min, logic [6:0] sp);
    return !tank_low && (avg > sp_min) && (avg < sp);
  endfunction

endpackage

FILE: src/smic_debounce.sv
// stable-count debouncer for one pin: the flag follows the pin after
// TICKS consecutive differing ticks; depends on smic_pkg (dbn_t)
module smic_debounce #(
  parameter int TICKS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          pin,
  output smic_pkg::dbn_t st
);

  localparam int CntW = $clog2(TICKS + 1);

  logic            flag_r, flag_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW:0]   sum;
  logic            chg;

  // count ticks on which the pin differs from the flag
  always_comb begin
    sum      = {1'b0, cnt_r} + (CntW+1)'(1);
    flag_nxt = flag_r;
    cnt_nxt  = cnt_r;
    chg      = 1'b0;
    if (en) begin
      if (pin == flag_r) begin
        cnt_nxt = '0;
      end else if (sum >= (CntW+1)'(TICKS)) begin
        cnt_nxt  = '0;
        flag_nxt = pin;
        chg      = 1'b1;
      end else begin
        cnt_nxt = sum[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      flag_r <= flag_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign st.flag     = flag_r;
  assign st.flag_nxt = flag_nxt;
  assign st.chg      = chg;

endmodule

FILE: src/soil_moisture_irrigation_control.sv
// irrigation pump controller top level: input register, one-pass update, message buffer
// depends on smic_pkg, smic_debounce and soil_moisture_irrigation_control_assert.svh
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid / tready    tuser: op; tdata: adc, floats, button, pump req, setpoint
//   out_     master     tvalid / tready    tdata: value, pump_on; tuser: kind; tlast
//   cfg_     write      cfg_we             cfg_addr, cfg_wdata
//
// a request passes the input register and is worked out once the message buffer
// is free, its messages then registered in the buffer, which sends its 0 to 5
// messages one per cycle while out_tready is high; a new request is taken every
// cycle when each yields at most one message and out_tready is high (the single
// output beat sets the rate). reset is synchronous and active low; no clearing pass.
// out_tready low holds the buffer and, once the input register is full, in_tready.
module soil_moisture_irrigation_control #(
  parameter int DEBOUNCE_TICKS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic [31:0] in_tdata,   // adc_sample[9:0], tank_low_pin[10], tank_high_pin[11],
                                  // button_pin[12], pump_request[13],
                                  // setpoint_value[29:14]
  // message stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // msg_value[6:0], pump_on[7]
  output logic [2:0]  out_tuser,  // msg_kind[2:0]
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int NS = smic_pkg::NSLOT;

  // configuration registers
  logic [23:0] dose_r;
  logic [15:0] sample_r;
  logic [23:0] report_r;
  logic [6:0]  sp_min_r;
  logic [6:0]  sp_max_r;

  // input register
  logic               s1_vld_r;
  logic [1:0]         s1_op_r;
  logic [6:0]         s1_pct_r;
  logic               s1_low_r, s1_high_r, s1_btn_r, s1_preq_r;
  logic signed [15:0] s1_spv_r;
  logic               in_fire, s1_adv, buf_free, is_tick;

  // controller state
  logic        pump_r, pump_nxt;
  logic [23:0] el_r, el_nxt;
  logic [15:0] ss_r, ss_nxt;
  logic [23:0] sr_r, sr_nxt;
  logic [6:0]  avg_r, avg_nxt;
  logic [6:0]  sp_r, sp_nxt;

  // message buffer
  logic [NS-1:0]  vld_r, vld_nxt, mask, first;
  smic_pkg::msg_t slot_r   [NS];
  smic_pkg::msg_t slot_nxt [NS];
  smic_pkg::msg_t cur;
  logic           out_fire, one_left;

  smic_pkg::dbn_t dl, dh, db;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dose_r   <= 24'd9500;
      sample_r <= 16'd1000;
      report_r <= 24'd60000;
      sp_min_r <= 7'd10;
      sp_max_r <= 7'd80;
    end else if (cfg_we) begin
      case (cfg_addr)
        smic_pkg::CFG_DOSE:   dose_r   <= cfg_wdata;
        smic_pkg::CFG_SAMPLE: sample_r <= cfg_wdata[15:0];
        smic_pkg::CFG_REPORT: report_r <= cfg_wdata;
        smic_pkg::CFG_SP_MIN: sp_min_r <= cfg_wdata[6:0];
        smic_pkg::CFG_SP_MAX: sp_max_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // handshake between input register and message buffer
  assign first    = vld_r & (~vld_r + NS'(1));
  assign one_left = (vld_r & ~first) == '0;
  assign out_fire = out_tvalid && out_tready;
  assign buf_free = (vld_r == '0) || (out_tready && one_left);
  assign s1_adv   = s1_vld_r && buf_free;
  assign in_tready = !s1_vld_r || buf_free;
  assign in_fire   = in_tvalid && in_tready;
  assign is_tick   = s1_op_r == smic_pkg::OP_TICK;

  // input register; moisture percent is worked out on the way in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_tuser;
      s1_pct_r  <= smic_pkg::percent_of(in_tdata[9:0]);
      s1_low_r  <= in_tdata[10];
      s1_high_r <= in_tdata[11];
      s1_btn_r  <= in_tdata[12];
      s1_preq_r <= in_tdata[13];
      s1_spv_r  <= $signed(in_tdata[29:14]);
    end
  end

  // debouncers for the two floats and the button
  smic_debounce #(.TICKS(DEBOUNCE_TICKS)) u_dbn_low (
    .clk(clk), .rst_n(rst_n), .en(s1_adv && is_tick), .pin(s1_low_r), .st(dl)
  );
  smic_debounce #(.TICKS(DEBOUNCE_TICKS)) u_dbn_high (
    .clk(clk), .rst_n(rst_n), .en(s1_adv && is_tick), .pin(s1_high_r), .st(dh)
  );
  smic_debounce #(.TICKS(DEBOUNCE_TICKS)) u_dbn_btn (
    .clk(clk), .rst_n(rst_n), .en(s1_adv && is_tick), .pin(s1_btn_r), .st(db)
  );

  // one-pass update of the controller; slots in emission order:
  // dose end, low float, high float, button or command, report, auto start
  always_comb begin
    logic btn_try;
    logic [10:0] y;
    pump_nxt = pump_r;
    el_nxt   = el_r;
    ss_nxt   = ss_r;
    sr_nxt   = sr_r;
    avg_nxt  = avg_r;
    sp_nxt   = sp_r;
    mask     = '0;
    btn_try  = 1'b0;
    y        = '0;
    for (int i = 0; i < NS; i++) begin
      slot_nxt[i] = '0;
    end
    if (s1_adv) begin
      case (s1_op_r)
        smic_pkg::OP_TICK: begin
          // dose timer
          if (pump_nxt) begin
            if (el_nxt != smic_pkg::MAX24) begin
              el_nxt = el_nxt + 24'd1;
            end
            if (el_nxt >= dose_r) begin
              pump_nxt    = 1'b0;
              el_nxt      = '0;
              mask[0]     = 1'b1;
              slot_nxt[0] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd0, 1'b0);
            end
          end
          // float changes
          if (dl.chg) begin
            mask[1]     = 1'b1;
            slot_nxt[1] = smic_pkg::mk_msg(smic_pkg::KIND_TANK_LOW,
                                           {6'd0, dl.flag_nxt}, pump_nxt);
          end
          if (dh.chg) begin
            mask[2]     = 1'b1;
            slot_nxt[2] = smic_pkg::mk_msg(smic_pkg::KIND_TANK_HIGH,
                                           {6'd0, dh.flag_nxt}, pump_nxt);
          end
          // button press makes a start attempt
          btn_try = db.chg && db.flag_nxt;
          if (btn_try) begin
            mask[3] = 1'b1;
            if (smic_pkg::start_ok(dl.flag_nxt, avg_nxt, sp_min_r, sp_nxt)) begin
              pump_nxt    = 1'b1;
              el_nxt      = '0;
              slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd1, 1'b1);
            end else begin
              slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd0, pump_nxt);
            end
          end
          // saturating period timers
          if (ss_nxt != smic_pkg::MAX16) begin
            ss_nxt = ss_nxt + 16'd1;
          end
          if (sr_nxt != smic_pkg::MAX24) begin
            sr_nxt = sr_nxt + 24'd1;
          end
          // moisture filter
          if (!pump_nxt && ss_nxt >= sample_r) begin
            y       = 11'(avg_nxt) * 11'd10 + 11'(s1_pct_r);
            avg_nxt = smic_pkg::div11(y);
            ss_nxt  = '0;
          end
          // report and automatic watering
          if (!pump_nxt && sr_nxt >= report_r) begin
            mask[4]     = 1'b1;
            slot_nxt[4] = smic_pkg::mk_msg(smic_pkg::KIND_MOISTURE, avg_nxt, pump_nxt);
            sr_nxt      = '0;
            if (avg_nxt < sp_nxt && !btn_try) begin
              mask[5] = 1'b1;
              if (smic_pkg::start_ok(dl.flag_nxt, avg_nxt, sp_min_r, sp_nxt)) begin
                pump_nxt    = 1'b1;
                el_nxt      = '0;
                slot_nxt[5] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd1, 1'b1);
              end else begin
                slot_nxt[5] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd0, pump_nxt);
              end
            end
          end
        end
        smic_pkg::OP_PUMP: begin
          mask[3] = 1'b1;
          if (s1_preq_r && smic_pkg::start_ok(dl.flag, avg_r, sp_min_r, sp_r)) begin
            pump_nxt    = 1'b1;
            el_nxt      = '0;
            slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd1, 1'b1);
          end else if (s1_preq_r) begin
            slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd0, pump_r);
          end else begin
            pump_nxt    = 1'b0;
            el_nxt      = '0;
            slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_STATUS, 7'd0, 1'b0);
          end
        end
        smic_pkg::OP_SETPT: begin
          // clamp, minimum first
          if (s1_spv_r < $signed({9'd0, sp_min_r})) begin
            sp_nxt = sp_min_r;
          end else if (s1_spv_r > $signed({9'd0, sp_max_r})) begin
            sp_nxt = sp_max_r;
          end else begin
            sp_nxt = s1_spv_r[6:0];
          end
          mask[3]     = 1'b1;
          slot_nxt[3] = smic_pkg::mk_msg(smic_pkg::KIND_SETPOINT, sp_nxt, pump_r);
        end
        default: ;
      endcase
    end
  end

  // controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_r <= 1'b0;
      el_r   <= '0;
      ss_r   <= '0;
      sr_r   <= '0;
      avg_r  <= '0;
      sp_r   <= 7'd65;
    end else begin
      pump_r <= pump_nxt;
      el_r   <= el_nxt;
      ss_r   <= ss_nxt;
      sr_r   <= sr_nxt;
      avg_r  <= avg_nxt;
      sp_r   <= sp_nxt;
    end
  end

  // message buffer: load a whole request's messages, drain lowest slot first
  always_comb begin
    vld_nxt = vld_r;
    if (s1_adv) begin
      vld_nxt = mask;
    end else if (out_fire) begin
      vld_nxt = vld_r & ~first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < NS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  // select the lowest pending slot
  always_comb begin
    cur = '0;
    for (int i = 0; i < NS; i++) begin
      cur = cur | (slot_r[i] & {$bits(smic_pkg::msg_t){first[i]}});
    end
  end

  assign out_tvalid = vld_r != '0;
  assign out_tdata  = {cur.pump_on, cur.value};
  assign out_tuser  = cur.kind;
  assign out_tlast  = one_left;

  // checks
  `include "soil_moisture_irrigation_control_assert.svh"

  `SMIC_ASSERT_ALWAYS(a_avg_range, avg_r <= 7'd100, "moisture average above 100")
  `SMIC_ASSERT_ALWAYS(a_one_start_try, !(vld_r[3] && vld_r[5]),
                      "button and automatic start attempts in one request")
  `SMIC_ASSERT_ALWAYS(a_max_msgs, $countones(vld_r) <= 5, "more than five messages pending")
  `SMIC_ASSERT_NEXT(a_stop_cmd, s1_adv && s1_op_r == smic_pkg::OP_PUMP && !s1_preq_r,
                    !pump_r && el_r == '0, "stop command left pump running")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the irrigation pump controller: directed and random requests
// with a request-level predictor and an in-order message check; needs smic_pkg and the dut
`timescale 1ns / 100ps

module tb_top;

  localparam int         DEBOUNCE_TICKS = 10;
  localparam logic [1:0] OP_IGNORED     = 2'd3;
  localparam int         HALF_PERIOD    = 4;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         IDLE_GAP       = 12;
  localparam int         HOLD_CYCLES    = 250;

  // one request, last field in the lowest bits
  typedef struct packed {
    logic [15:0] setpoint_value;
    logic        pump_request;
    logic        button_pin;
    logic        tank_high_pin;
    logic        tank_low_pin;
    logic [9:0]  adc_sample;
    logic [1:0]  op;
  } req_t;

  // one predicted message
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] value;
    logic       pump_on;
    logic       last;
  } ctrl_msg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  soil_moisture_irrigation_control #(
    .DEBOUNCE_TICKS(DEBOUNCE_TICKS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // controller state as the predictor sees it
  logic        m_pump;
  logic [23:0] m_dose_el;
  logic [15:0] m_since_sample;
  logic [23:0] m_since_report;
  logic [6:0]  m_avg;
  logic [6:0]  m_setpoint;
  logic        m_low, m_high, m_btn;
  logic [3:0]  m_deb [3];

  // register copies
  logic [23:0] r_dose;
  logic [15:0] r_sample;
  logic [23:0] r_report;
  logic [6:0]  r_sp_min, r_sp_max;

  ctrl_msg_t pending_msgs [$];
  ctrl_msg_t step_msgs [$];

  int mismatches = 0;
  int msg_seen = 0;
  int cycle_count = 0;

  // sender pacing and pin levels of the tick generator
  int   burst_left = 0;
  logic pin_lvl [3] = '{1'b0, 1'b0, 1'b0};
  int   pin_hold [3] = '{0, 0, 0};

  // receiver stall pattern
  bit hold_request = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_span = 0;
  int rx_phase = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_controller_model();
    r_dose         = 24'd9500;
    r_sample       = 16'd1000;
    r_report       = 24'd60000;
    r_sp_min       = 7'd10;
    r_sp_max       = 7'd80;
    m_pump         = 1'b0;
    m_dose_el      = '0;
    m_since_sample = '0;
    m_since_report = '0;
    m_avg          = '0;
    m_setpoint     = 7'd65;
    m_low          = 1'b0;
    m_high         = 1'b0;
    m_btn          = 1'b0;
    for (int i = 0; i < 3; i++) m_deb[i] = '0;
  endfunction

  function automatic void load_model_reg(logic [2:0] idx, logic [23:0] v);
    case (idx)
      smic_pkg::CFG_DOSE:   r_dose = v;
      smic_pkg::CFG_SAMPLE: r_sample = v[15:0];
      smic_pkg::CFG_REPORT: r_report = v;
      smic_pkg::CFG_SP_MIN: r_sp_min = v[6:0];
      smic_pkg::CFG_SP_MAX: r_sp_max = v[6:0];
      default: ;
    endcase
  endfunction

  function automatic void queue_msg(logic [2:0] kind, logic [6:0] value);
    ctrl_msg_t m;
    m.kind    = kind;
    m.value   = value;
    m.pump_on = m_pump;
    m.last    = 1'b0;
    step_msgs.push_back(m);
  endfunction

  // watering attempt, also restarts a running dose
  function automatic void attempt_start();
    if (!m_low && m_avg > r_sp_min && m_avg < m_setpoint) begin
      m_pump    = 1'b1;
      m_dose_el = '0;
      queue_msg(smic_pkg::KIND_STATUS, 7'd1);
    end else begin
      queue_msg(smic_pkg::KIND_STATUS, 7'd0);
    end
  endfunction

  function automatic void halt_pump();
    m_pump    = 1'b0;
    m_dose_el = '0;
    queue_msg(smic_pkg::KIND_STATUS, 7'd0);
  endfunction

  // stable-count debounce, true when the flag is to take the pin value
  function automatic logic pin_settled(int idx, logic pin, logic flag);
    if (pin == flag) begin
      m_deb[idx] = '0;
      return 1'b0;
    end
    m_deb[idx] = m_deb[idx] + 4'd1;
    if (int'(m_deb[idx]) >= DEBOUNCE_TICKS) begin
      m_deb[idx] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [6:0] soil_percent(logic [9:0] adc);
    int d;
    d = 670 - int'(adc);
    if (d <= 0) return 7'd0;
    if (d * 100 / 393 > 100) return 7'd100;
    return 7'(d * 100 / 393);
  endfunction

  function automatic void model_tick(req_t r);
    logic tried;
    tried = 1'b0;
    // dose timing
    if (m_pump) begin
      if (m_dose_el != smic_pkg::MAX24) m_dose_el = m_dose_el + 24'd1;
      if (m_dose_el >= r_dose) halt_pump();
    end
    // floats and button
    if (pin_settled(0, r.tank_low_pin, m_low)) begin
      m_low = r.tank_low_pin;
      queue_msg(smic_pkg::KIND_TANK_LOW, {6'd0, m_low});
    end
    if (pin_settled(1, r.tank_high_pin, m_high)) begin
      m_high = r.tank_high_pin;
      queue_msg(smic_pkg::KIND_TANK_HIGH, {6'd0, m_high});
    end
    if (pin_settled(2, r.button_pin, m_btn)) begin
      m_btn = r.button_pin;
      if (m_btn) begin
        attempt_start();
        tried = 1'b1;
      end
    end
    // saturating timers
    if (m_since_sample != smic_pkg::MAX16) m_since_sample = m_since_sample + 16'd1;
    if (m_since_report != smic_pkg::MAX24) m_since_report = m_since_report + 24'd1;
    // moisture filter while the pump is off
    if (!m_pump && m_since_sample >= r_sample) begin
      m_avg = 7'((int'(m_avg) * 10 + int'(soil_percent(r.adc_sample))) / 11);
      m_since_sample = '0;
    end
    // report and automatic watering, skipped after a button attempt
    if (!m_pump && m_since_report >= r_report) begin
      queue_msg(smic_pkg::KIND_MOISTURE, m_avg);
      m_since_report = '0;
      if (m_avg < m_setpoint && !tried) attempt_start();
    end
  endfunction

  function automatic void model_setpoint(req_t r);
    int v;
    v = int'($signed(r.setpoint_value));
    if (v < int'(r_sp_min)) m_setpoint = r_sp_min;
    else if (v > int'(r_sp_max)) m_setpoint = r_sp_max;
    else m_setpoint = 7'(v);
    queue_msg(smic_pkg::KIND_SETPOINT, m_setpoint);
  endfunction

  // works out the messages of one accepted request
  function automatic void advance_controller(req_t r);
    ctrl_msg_t m;
    step_msgs.delete();
    case (r.op)
      smic_pkg::OP_TICK:  model_tick(r);
      smic_pkg::OP_PUMP:  if (r.pump_request) attempt_start(); else halt_pump();
      smic_pkg::OP_SETPT: model_setpoint(r);
      default: ;
    endcase
    if (step_msgs.size() > 0) begin
      m = step_msgs.pop_back();
      m.last = 1'b1;
      step_msgs.push_back(m);
    end
    foreach (step_msgs[i]) pending_msgs.push_back(step_msgs[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at message %0d: %s got %0d want %0d", msg_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_msg
    ctrl_msg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_msgs.size() == 0) begin
        report_mismatch("message with nothing pending, kind", int'(out_tuser), -1);
      end else begin
        want = pending_msgs.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("msg_kind", int'(out_tuser), int'(want.kind));
        if (out_tdata[6:0] !== want.value)
          report_mismatch("msg_value", int'(out_tdata[6:0]), int'(want.value));
        if (out_tdata[7] !== want.pump_on)
          report_mismatch("pump_on", int'(out_tdata[7]), int'(want.pump_on));
        if (out_tlast !== want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
      end
      msg_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 80);
    end
    rx_span--;
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ((rx_phase % 8) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic req_t build_req(logic [1:0] op, logic [9:0] adc, logic low, logic high,
                                     logic btn, logic preq, logic [15:0] spv);
    req_t r;
    r.op             = op;
    r.adc_sample     = adc;
    r.tank_low_pin   = low;
    r.tank_high_pin  = high;
    r.button_pin     = btn;
    r.pump_request   = preq;
    r.setpoint_value = spv;
    return r;
  endfunction

  // tick with pins held for runs, so that the debounce can settle
  function automatic req_t make_tick();
    req_t r;
    int   sel;
    r = req_t'($urandom);
    r.op = smic_pkg::OP_TICK;
    for (int i = 0; i < 3; i++) begin
      if (pin_hold[i] == 0) begin
        pin_lvl[i]  = (i == 0) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
        pin_hold[i] = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : $urandom_range(10, 30);
      end
      pin_hold[i]--;
    end
    r.tank_low_pin  = pin_lvl[0];
    r.tank_high_pin = pin_lvl[1];
    r.button_pin    = pin_lvl[2];
    sel = $urandom_range(0, 99);
    if (sel < 70) r.adc_sample = 10'($urandom_range(277, 620));
    else if (sel < 85) r.adc_sample = 10'($urandom_range(0, 276));
    else r.adc_sample = 10'($urandom_range(621, 1023));
    return r;
  endfunction

  // op travels on tuser, the other fields packed in tdata
  task automatic send_request(input req_t r);
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.setpoint_value, r.pump_request, r.button_pin, r.tank_high_pin,
                  r.tank_low_pin, r.adc_sample};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_controller(r);
  endtask

  // bursts of random length with random gaps
  task automatic pace_sender(input bit gaps);
    int gap;
    if (!gaps) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // wait until every predicted message has come, then let the pipeline empty
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic program_regs(input logic [23:0] dose, input logic [23:0] sample,
                              input logic [23:0] report, input logic [23:0] sp_min,
                              input logic [23:0] sp_max);
    logic [23:0] vals [5];
    logic [2:0]  regs [5];
    vals = '{dose, sample, report, sp_min, sp_max};
    regs = '{smic_pkg::CFG_DOSE, smic_pkg::CFG_SAMPLE, smic_pkg::CFG_REPORT,
             smic_pkg::CFG_SP_MIN, smic_pkg::CFG_SP_MAX};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      load_model_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic retune(input logic [23:0] dose, input logic [23:0] sample,
                        input logic [23:0] report, input logic [23:0] sp_min,
                        input logic [23:0] sp_max);
    settle_block();
    program_regs(dose, sample, report, sp_min, sp_max);
  endtask

  // ---------------------------------------------------------------- tests

  // clamping at both ends and the extremes of the signed field
  task automatic test_setpoint_clamp();
    send_request(build_req(smic_pkg::OP_SETPT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000));
    send_request(build_req(smic_pkg::OP_SETPT, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, 16'h7FFF));
    send_request(build_req(smic_pkg::OP_SETPT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
    send_request(build_req(smic_pkg::OP_SETPT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd100));
    send_request(build_req(smic_pkg::OP_SETPT, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd50));
  endtask

  // ignored op, stop, and a start that fails on a dry average
  task automatic test_pump_commands();
    send_request(build_req(OP_IGNORED, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    send_request(build_req(smic_pkg::OP_PUMP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
    send_request(build_req(smic_pkg::OP_PUMP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
  endtask

  // wet readings raise the average, the report starts a dose, restart and stop
  task automatic test_watering_cycle();
    repeat (4)
      send_request(build_req(smic_pkg::OP_TICK, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
    send_request(build_req(smic_pkg::OP_PUMP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
    send_request(build_req(smic_pkg::OP_PUMP, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
  endtask

  // all pins high until both floats and the button settle on one tick
  task automatic test_debounce();
    repeat (DEBOUNCE_TICKS)
      send_request(build_req(smic_pkg::OP_TICK, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
  endtask

  task automatic test_random_traffic(input int n_items, input bit gaps);
    req_t r;
    int   sent;
    int   sel;
    sent = 0;
    while (sent < n_items) begin
      pace_sender(gaps);
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        r = make_tick();
      end else begin
        r = req_t'($urandom);
        if (sel < 86) begin
          r.op = smic_pkg::OP_PUMP;
        end else if (sel < 95) begin
          r.op = smic_pkg::OP_SETPT;
          if ($urandom_range(0, 9) < 6)
            r.setpoint_value = 16'($urandom_range(0, 115)) - 16'd5;
        end else begin
          r.op = OP_IGNORED;
        end
      end
      send_request(r);
      if (r.op != OP_IGNORED) sent++;
    end
  endtask

  // long receiver hold-off while ticks keep coming, then a full drain
  task automatic test_backpressure();
    retune(24'd4, 24'd0, 24'd0, 24'd10, 24'd80);
    hold_request = 1'b1;
    repeat (40) send_request(make_tick());
    settle_block();
  endtask

  initial begin
    reset_controller_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(24'd3, 24'd0, 24'd2, 24'd10, 24'd80);
    test_setpoint_clamp();
    test_pump_commands();
    test_watering_cycle();
    test_debounce();

    // short periods, no sender gaps
    retune(24'd12, 24'd2, 24'd9, 24'd10, 24'd80);
    test_random_traffic(90, 1'b0);
    // zero periods: report and filter on every tick while the pump is off, dose of zero
    retune(24'd0, 24'd0, 24'd0, 24'd0, 24'd100);
    test_random_traffic(70, 1'b1);
    // setpoint limits crossed
    retune(24'd20, 24'd1, 24'd6, 24'd70, 24'd30);
    test_random_traffic(80, 1'b1);
    // largest periods
    retune(24'hFFFFFF, 24'd65535, 24'hFFFFFF, 24'd100, 24'd0);
    test_random_traffic(40, 1'b1);
    test_backpressure();
    // random settings
    retune(24'($urandom_range(0, 40)), 24'($urandom_range(0, 8)), 24'($urandom_range(0, 30)),
           24'($urandom_range(0, 40)), 24'($urandom_range(50, 100)));
    test_random_traffic(90, 1'b1);
    retune(24'($urandom_range(0, 60)), 24'($urandom_range(0, 10)), 24'($urandom_range(0, 40)),
           24'($urandom_range(0, 50)), 24'($urandom_range(40, 100)));
    test_random_traffic(90, 1'b1);

    settle_block();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/smic_pkg.sv
src/smic_debounce.sv
src/soil_moisture_irrigation_control.sv
tb/tb_top.sv
